>>> src/fas_pkg.sv
// ----------------------------------------------------------------------------
// fas_pkg: shared types and constants for the frame animation sequencer
// Request payload structs, mode and register codes, divider sizing and the
// controller state type.
// ----------------------------------------------------------------------------
package fas_pkg;

  // Frame storage limit of the animation table and the cap used on frame_count
  localparam int MAX_FRAMES = 256;
  localparam int FRAME_CAP  = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int FRAME_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int RATE_W   = 24;
  localparam int THRESH_W = 16;
  localparam int SAMPLE_W = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Product of elapsed ticks and the Q16 rate
  localparam int PROD_W = TIME_W + RATE_W;
  localparam int FRAC_W = 16;

  // Iterative divider: quotient bits resolved per cycle and cycle count
  localparam int DIV_BITS_PER_CYC = 8;
  localparam int DIV_CYCLES       = TIME_W / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Animation modes
  localparam logic [1:0] ANIM_LOOP     = 2'd0;
  localparam logic [1:0] ANIM_PINGPONG = 2'd1;
  localparam logic [1:0] ANIM_ONCE     = 2'd2;
  localparam logic [1:0] ANIM_FROZEN   = 2'd3;

  // Trigger modes (the unused code behaves as free running)
  localparam logic [1:0] TRIG_FREE = 2'd0;
  localparam logic [1:0] TRIG_JUMP = 2'd1;
  localparam logic [1:0] TRIG_RUN  = 2'd2;

  // Step direction, two's complement
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd3;

  // Actions
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_SET    = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_Q16    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANCE_THR  = 3'd4;

  // Reset value of the rate register
  localparam logic [RATE_W-1:0] RATE_RESET = 24'd983;

  typedef struct packed {
    logic                action;
    logic [TIME_W-1:0]   now_ms;
    logic [FRAME_W-1:0]  new_frame;
    logic [SAMPLE_W-1:0] chance_sample;
    logic [SAMPLE_W-1:0] pick_sample;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               is_running;
    logic               is_finished;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic mul;
    logic div_init;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

endpackage

>>> src/fas_datapath.sv
// ----------------------------------------------------------------------------
// fas_datapath: registers and arithmetic of the frame animation sequencer
// Holds configuration and animation state, the latched request, the elapsed
// frame multiplier, the iterative divider and the result register.
// ----------------------------------------------------------------------------
module fas_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fas_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [fas_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  fas_pkg::in_item_t               in_data,
  input  fas_pkg::dp_cmd_t                cmd,
  output fas_pkg::dp_status_t             status,
  output fas_pkg::out_item_t              out_data
);
  import fas_pkg::*;

  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(FRAME_CAP);

  // Configuration
  logic [1:0]          anim_mode;
  logic [1:0]          trigger_mode;
  logic [COUNT_W-1:0]  frame_count;
  logic [RATE_W-1:0]   rate_q16;
  logic [THRESH_W-1:0] chance_threshold;

  // Animation state
  logic [FRAME_W-1:0] cur_frame;
  logic [1:0]         step_dir;
  logic [TIME_W-1:0]  start_ms;
  logic               run_flag;

  // Working registers
  in_item_t           item;
  logic [PROD_W-1:0]  prod;
  logic [TIME_W-1:0]  quot;
  logic [COUNT_W-1:0] rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Combinational values
  logic [COUNT_W-1:0] n_eff;
  logic               hit;
  logic               run_start;
  logic [TIME_W-1:0]  delta;
  logic [PROD_W-FRAC_W-1:0] prod_hi;
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  quot_next;
  logic [COUNT_W-1:0] rem_next;
  logic [SAMPLE_W+COUNT_W-1:0] pick_prod;

  logic [FRAME_W-1:0] cur_frame_next;
  logic [1:0]         step_dir_next;
  logic [TIME_W-1:0]  start_ms_next;
  logic               run_flag_next;
  logic [COUNT_W-1:0] last_frame;
  logic [FRAME_W-1:0] rem_frame;
  logic [COUNT_W-1:0] back_frame;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      anim_mode        <= ANIM_LOOP;
      trigger_mode     <= TRIG_FREE;
      frame_count      <= '0;
      rate_q16         <= RATE_RESET;
      chance_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ANIM_MODE:   anim_mode        <= cfg_wdata[1:0];
        REG_TRIG_MODE:   trigger_mode     <= cfg_wdata[1:0];
        REG_FRAME_COUNT: frame_count      <= cfg_wdata[COUNT_W-1:0];
        REG_RATE_Q16:    rate_q16         <= cfg_wdata[RATE_W-1:0];
        REG_CHANCE_THR:  chance_threshold <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame count and trigger test
  assign n_eff     = (frame_count < CAP) ? frame_count : CAP;
  assign hit       = {1'b0, item.chance_sample} < chance_threshold;
  assign run_start = (trigger_mode == TRIG_RUN) && !run_flag && hit;

  // A run start restarts timing at this request's time stamp
  assign delta = run_start ? '0 : (item.now_ms - start_ms);

  // Saturated elapsed frame count
  assign prod_hi = prod[PROD_W-1:FRAC_W];
  assign elapsed = (|prod_hi[PROD_W-FRAC_W-1:TIME_W]) ? '1 : prod_hi[TIME_W-1:0];

  // Restoring divide by the frame count, several quotient bits per cycle
  always_comb begin
    logic [COUNT_W:0]   sh;
    logic [COUNT_W-1:0] r;
    logic [TIME_W-1:0]  q;
    r = rem;
    q = quot;
    for (int i = 0; i < DIV_BITS_PER_CYC; i++) begin
      sh = {r, q[TIME_W-1]};
      q  = {q[TIME_W-2:0], 1'b0};
      if (sh >= {1'b0, n_eff}) begin
        sh   = sh - {1'b0, n_eff};
        q[0] = 1'b1;
      end
      r = sh[COUNT_W-1:0];
    end
    quot_next = q;
    rem_next  = r;
  end

  // Request latch, multiplier and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_data;
    if (cmd.mul) prod <= PROD_W'(delta) * PROD_W'(rate_q16);
    if (cmd.div_init) begin
      quot <= elapsed;
      rem  <= '0;
    end else if (cmd.div_step) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  // Divider cycle count
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  assign status.div_last = (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1));

  // Random frame pick and frames derived from the remainder
  assign pick_prod  = (SAMPLE_W+COUNT_W)'(item.pick_sample) * (SAMPLE_W+COUNT_W)'(n_eff);
  assign rem_frame  = rem[FRAME_W-1:0];
  assign back_frame = n_eff - rem - COUNT_W'(1);
  assign last_frame = (n_eff == '0) ? '0 : (n_eff - COUNT_W'(1));

  // Next animation state once quotient and remainder are ready
  always_comb begin
    logic [FRAME_W-1:0] cf;
    logic [1:0]         sd;
    logic               rf;
    logic               go;
    cur_frame_next = cur_frame;
    step_dir_next  = step_dir;
    start_ms_next  = start_ms;
    run_flag_next  = run_flag;
    cf = cur_frame;
    sd = step_dir;
    rf = run_flag;
    go = 1'b0;
    if (item.action == ACT_SET) begin
      cur_frame_next = item.new_frame;
      start_ms_next  = item.now_ms;
    end else if (anim_mode == ANIM_FROZEN) begin
      go = 1'b0;
    end else if (trigger_mode == TRIG_JUMP) begin
      if (hit) cur_frame_next = pick_prod[SAMPLE_W+FRAME_W-1:SAMPLE_W];
    end else begin
      if (run_start) begin
        cf = '0;
        sd = DIR_NONE;
        rf = 1'b1;
        start_ms_next = item.now_ms;
      end
      go = (n_eff != '0) && ((trigger_mode != TRIG_RUN) || rf);
      if (go) begin
        case (anim_mode)
          ANIM_LOOP: begin
            if (sd == DIR_FWD) begin
              if (rem_frame < cf) begin
                cf = '0;
                rf = 1'b0;
              end else begin
                cf = rem_frame;
              end
            end else begin
              // candidate is zero or negative
              if (((sd == DIR_BACK) && (rem != '0)) || (cf != '0)) rf = 1'b0;
              cf = '0;
            end
          end
          ANIM_PINGPONG: begin
            if (quot[0]) begin
              sd = DIR_BACK;
              cf = back_frame[FRAME_W-1:0];
            end else if (sd == DIR_BACK) begin
              rf = 1'b0;
            end else begin
              sd = DIR_FWD;
              cf = rem_frame;
            end
          end
          default: begin
            // play once: clamp at the last frame
            if (quot != '0) begin
              rf = 1'b0;
              cf = last_frame[FRAME_W-1:0];
            end else begin
              cf = rem_frame;
            end
          end
        endcase
      end
      cur_frame_next = cf;
      step_dir_next  = sd;
      run_flag_next  = rf;
    end
  end

  // Commit state and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_frame <= '0;
      step_dir  <= DIR_FWD;
      start_ms  <= '0;
      run_flag  <= 1'b0;
    end else if (cmd.commit) begin
      cur_frame <= cur_frame_next;
      step_dir  <= step_dir_next;
      start_ms  <= start_ms_next;
      run_flag  <= run_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.frame_index <= cur_frame_next;
      out_data.is_running  <= run_flag_next;
      out_data.is_finished <= (anim_mode == ANIM_ONCE) &&
                              ({1'b0, cur_frame_next} == last_frame);
    end
  end

endmodule

>>> src/fas_ctrl.sv
// ----------------------------------------------------------------------------
// fas_ctrl: sequencing state machine of the frame animation sequencer
// Steps one request through multiply, saturate and divide, then commits the
// result when the output register is free. Owns both handshakes.
// ----------------------------------------------------------------------------
module fas_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fas_pkg::dp_status_t status,
  output fas_pkg::dp_cmd_t    cmd
);
  import fas_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SAT;
      ST_SAT:  state_next = ST_DIV;
      ST_DIV:  if (status.div_last) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_MUL:  cmd.mul      = 1'b1;
      ST_SAT:  cmd.div_init = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DONE: cmd.commit   = out_free;
      default: ;
    endcase
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> src/frame_animation_sequencer_top.sv
// ----------------------------------------------------------------------------
// frame_animation_sequencer_top: sprite frame animation sequencer
// Advances an animation frame from millisecond time stamps in loop,
// ping-pong, play-once or frozen mode, with random jump and run triggers.
// ----------------------------------------------------------------------------
// One request is handled at a time. After acceptance it passes through the
// elapsed-time multiply, a step that saturates and loads the divider, the
// divide by the frame count (8 quotient bits per cycle), and a commit of the
// new state into the result register. The result register lets a new request
// be accepted while the previous result still waits; a result still held when
// the next request reaches its commit stalls that commit. Configuration writes
// take effect at once and are meant for idle time.
module frame_animation_sequencer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fas_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [fas_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fas_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fas_pkg::out_item_t              out_data
);
  import fas_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fas_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

>>> src/fas_checker.sv
// ----------------------------------------------------------------------------
// fas_checker: port-level checks for the frame animation sequencer
// Watches the request and result handshakes of the top level.
// ----------------------------------------------------------------------------
module fas_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input fas_pkg::out_item_t out_data
);
  import fas_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // One request at a time: no acceptance right after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // A new result only appears while a request is in progress
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared with no request in progress");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind frame_animation_sequencer_top fas_checker u_fas_checker (.*);
